@@ design/skvt_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted key/value table package
// Field widths, operation codes, datapath command codes and the command and
// status structures shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package skvt_pkg;

   localparam int OP_W         = 2;
   localparam int KEY_W        = 8;
   localparam int VAL_W        = 8;
   localparam int POS_W        = 8;
   localparam int IX_W         = 9;
   localparam int CNT_W        = 9;
   localparam int ENTRY_W      = KEY_W + VAL_W;
   localparam int CAPACITY_DEF = 256;

   // Operation codes of a request.
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_CHANGE = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
   localparam logic [OP_W-1:0] OP_FIND   = 2'd3;

   // Read address source for the table memory.
   typedef logic [2:0] rd_src_type;
   localparam rd_src_type RS_HOLD     = 3'd0;
   localparam rd_src_type RS_ZERO     = 3'd1;
   localparam rd_src_type RS_COUNT_M1 = 3'd2;
   localparam rd_src_type RS_POS_P1   = 3'd3;
   localparam rd_src_type RS_DEC      = 3'd4;
   localparam rd_src_type RS_INC      = 3'd5;

   // Write address and data selection for the table memory.
   typedef logic [2:0] wr_sel_type;
   localparam wr_sel_type WS_SHIFT_UP  = 3'd0;
   localparam wr_sel_type WS_SHIFT_DN  = 3'd1;
   localparam wr_sel_type WS_NEW_AT_A1 = 3'd2;
   localparam wr_sel_type WS_NEW_AT_0  = 3'd3;
   localparam wr_sel_type WS_CHANGE    = 3'd4;

   // Source of the reported index.
   typedef logic [1:0] ix_sel_type;
   localparam ix_sel_type IX_NONE = 2'd0;
   localparam ix_sel_type IX_ZERO = 2'd1;
   localparam ix_sel_type IX_A    = 2'd2;
   localparam ix_sel_type IX_A1   = 2'd3;

   typedef struct packed {
      logic       load;
      rd_src_type rd_src;
      logic       wr_en;
      wr_sel_type wr_sel;
      logic       res_en;
      logic       res_ok;
      ix_sel_type res_ix;
      logic       res_val;
      logic       cnt_inc;
      logic       cnt_dec;
   } skvt_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            full;
      logic            empty;
      logic            pos_ok;
      logic            pos_last;
      logic            key_gt;
      logic            key_eq;
      logic            addr_zero;
      logic            addr_last;
   } skvt_sts_type;

endpackage

@@ design/skvt_ifs.sv @@
// ----------------------------------------------------------------------------
// Sorted key/value table channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface skvt_req_if;
   import skvt_pkg::*;

   logic             valid;
   logic             ready;
   logic [OP_W-1:0]  operation;
   logic [KEY_W-1:0] key;
   logic [VAL_W-1:0] value;
   logic [POS_W-1:0] position;

   modport source (output valid, output operation, output key, output value,
                   output position, input ready);
   modport sink   (input valid, input operation, input key, input value,
                   input position, output ready);
endinterface

interface skvt_rsp_if;
   import skvt_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    ok;
   logic signed [IX_W-1:0]  found_index;
   logic [VAL_W-1:0]        found_value;
   logic [CNT_W-1:0]        entry_count;

   modport source (output valid, output ok, output found_index, output found_value,
                   output entry_count, input ready);
   modport sink   (input valid, input ok, input found_index, input found_value,
                   input entry_count, output ready);
endinterface

@@ design/skvt_dpath.sv @@
// ----------------------------------------------------------------------------
// Sorted key/value table datapath
// Table memory, entry count, request and result registers.
// ----------------------------------------------------------------------------
module skvt_dpath #(
   parameter int CAPACITY = skvt_pkg::CAPACITY_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  skvt_pkg::skvt_cmd_type         cmd,
   output skvt_pkg::skvt_sts_type         sts,
   input  logic [skvt_pkg::OP_W-1:0]      req_operation,
   input  logic [skvt_pkg::KEY_W-1:0]     req_key,
   input  logic [skvt_pkg::VAL_W-1:0]     req_value,
   input  logic [skvt_pkg::POS_W-1:0]     req_position,
   output logic                           rsp_ok,
   output logic signed [skvt_pkg::IX_W-1:0] rsp_found_index,
   output logic [skvt_pkg::VAL_W-1:0]     rsp_found_value,
   output logic [skvt_pkg::CNT_W-1:0]     rsp_entry_count
);
   import skvt_pkg::*;

   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int IDX_W  = $clog2(CAPACITY + 1);

   logic [ENTRY_W-1:0] mem [CAPACITY];

   logic [OP_W-1:0]    op_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [VAL_W-1:0]   val_ff;
   logic [POS_W-1:0]   pos_ff;
   logic [IDX_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   rd_addr_ff, rd_addr_in;
   logic [ENTRY_W-1:0] rdata_ff;
   logic               ok_ff;
   logic [IX_W-1:0]    index_ff, index_in;
   logic [VAL_W-1:0]   fval_ff;

   logic [IDX_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic [KEY_W-1:0]   rd_key;
   logic [CNT_W-1:0]   count_x;
   logic [CNT_W-1:0]   pos_x;

   assign rd_key  = rdata_ff[ENTRY_W-1:VAL_W];
   assign count_x = CNT_W'(count_ff);
   assign pos_x   = CNT_W'(pos_ff);

   always_comb begin
      sts.op        = op_ff;
      sts.full      = (count_ff == IDX_W'(CAPACITY));
      sts.empty     = (count_ff == '0);
      sts.pos_ok    = (pos_x < count_x);
      sts.pos_last  = ((pos_x + CNT_W'(1)) == count_x);
      sts.key_gt    = (rd_key > key_ff);
      sts.key_eq    = (rd_key == key_ff);
      sts.addr_zero = (rd_addr_ff == '0);
      sts.addr_last = (rd_addr_ff == (count_ff - IDX_W'(1)));
   end

   always_comb begin
      case (cmd.rd_src)
         RS_ZERO:     rd_addr_in = '0;
         RS_COUNT_M1: rd_addr_in = count_ff - IDX_W'(1);
         RS_POS_P1:   rd_addr_in = IDX_W'(pos_x + CNT_W'(1));
         RS_DEC:      rd_addr_in = rd_addr_ff - IDX_W'(1);
         RS_INC:      rd_addr_in = rd_addr_ff + IDX_W'(1);
         default:     rd_addr_in = rd_addr_ff;
      endcase
   end

   always_comb begin
      case (cmd.wr_sel)
         WS_SHIFT_UP: begin
            wr_addr = rd_addr_ff + IDX_W'(1);
            wr_data = rdata_ff;
         end
         WS_SHIFT_DN: begin
            wr_addr = rd_addr_ff - IDX_W'(1);
            wr_data = rdata_ff;
         end
         WS_NEW_AT_A1: begin
            wr_addr = rd_addr_ff + IDX_W'(1);
            wr_data = {key_ff, val_ff};
         end
         WS_NEW_AT_0: begin
            wr_addr = '0;
            wr_data = {key_ff, val_ff};
         end
         WS_CHANGE: begin
            wr_addr = rd_addr_ff;
            wr_data = {key_ff, val_ff};
         end
         default: begin
            wr_addr = rd_addr_ff;
            wr_data = rdata_ff;
         end
      endcase
   end

   always_comb begin
      case (cmd.res_ix)
         IX_ZERO: index_in = '0;
         IX_A:    index_in = IX_W'(rd_addr_ff);
         IX_A1:   index_in = IX_W'(rd_addr_ff) + IX_W'(1);
         default: index_in = '1;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + IDX_W'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - IDX_W'(1);
      end
   end

   // Table memory: one write and one registered read each cycle.
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr[ADDR_W-1:0]] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[rd_addr_in[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      rd_addr_ff <= rd_addr_in;
      if (cmd.load) begin
         op_ff  <= req_operation;
         key_ff <= req_key;
         val_ff <= req_value;
         pos_ff <= req_position;
      end
      if (cmd.res_en) begin
         ok_ff    <= cmd.res_ok;
         index_ff <= index_in;
         fval_ff  <= cmd.res_val ? rdata_ff[VAL_W-1:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign rsp_ok          = ok_ff;
   assign rsp_found_index = $signed(index_ff);
   assign rsp_found_value = fval_ff;
   assign rsp_entry_count = count_x;

endmodule

@@ design/skvt_ctrl.sv @@
// ----------------------------------------------------------------------------
// Sorted key/value table controller
// Sequences the memory walk of each operation and the response handshake.
// ----------------------------------------------------------------------------
module skvt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  skvt_pkg::skvt_sts_type sts,
   output skvt_pkg::skvt_cmd_type cmd
);
   import skvt_pkg::*;

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_START     = 3'd1;
   localparam logic [2:0] S_INS_SHIFT = 3'd2;
   localparam logic [2:0] S_INS_EQ    = 3'd3;
   localparam logic [2:0] S_INS_LAST  = 3'd4;
   localparam logic [2:0] S_REM_SHIFT = 3'd5;
   localparam logic [2:0] S_SEARCH    = 3'd6;
   localparam logic [2:0] S_RESP      = 3'd7;

   logic [2:0] state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rd_src = RS_HOLD;
      cmd.wr_sel = WS_SHIFT_UP;
      cmd.res_ix = IX_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_START;
            end
         end
         S_START: begin
            case (sts.op)
               OP_INSERT: begin
                  if (sts.full) begin
                     cmd.res_en = 1'b1;
                     state_in   = S_RESP;
                  end else if (sts.empty) begin
                     cmd.wr_en   = 1'b1;
                     cmd.wr_sel  = WS_NEW_AT_0;
                     cmd.res_en  = 1'b1;
                     cmd.res_ok  = 1'b1;
                     cmd.res_ix  = IX_ZERO;
                     cmd.cnt_inc = 1'b1;
                     state_in    = S_RESP;
                  end else begin
                     cmd.rd_src = RS_COUNT_M1;
                     state_in   = S_INS_SHIFT;
                  end
               end
               OP_REMOVE: begin
                  if (!sts.pos_ok) begin
                     cmd.res_en = 1'b1;
                     state_in   = S_RESP;
                  end else if (sts.pos_last) begin
                     cmd.res_en  = 1'b1;
                     cmd.res_ok  = 1'b1;
                     cmd.cnt_dec = 1'b1;
                     state_in    = S_RESP;
                  end else begin
                     cmd.rd_src = RS_POS_P1;
                     state_in   = S_REM_SHIFT;
                  end
               end
               default: begin
                  if (sts.empty) begin
                     cmd.res_en = 1'b1;
                     state_in   = S_RESP;
                  end else begin
                     cmd.rd_src = RS_ZERO;
                     state_in   = S_SEARCH;
                  end
               end
            endcase
         end
         S_INS_SHIFT: begin
            if (sts.key_gt) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WS_SHIFT_UP;
               if (sts.addr_zero) begin
                  state_in = S_INS_LAST;
               end else begin
                  cmd.rd_src = RS_DEC;
               end
            end else begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WS_NEW_AT_A1;
               if (sts.key_eq && !sts.addr_zero) begin
                  cmd.rd_src = RS_DEC;
                  state_in   = S_INS_EQ;
               end else begin
                  cmd.res_en  = 1'b1;
                  cmd.res_ok  = 1'b1;
                  cmd.res_ix  = sts.key_eq ? IX_ZERO : IX_A1;
                  cmd.cnt_inc = 1'b1;
                  state_in    = S_RESP;
               end
            end
         end
         S_INS_EQ: begin
            if (sts.key_eq && !sts.addr_zero) begin
               cmd.rd_src = RS_DEC;
            end else begin
               cmd.res_en  = 1'b1;
               cmd.res_ok  = 1'b1;
               cmd.res_ix  = sts.key_eq ? IX_ZERO : IX_A1;
               cmd.cnt_inc = 1'b1;
               state_in    = S_RESP;
            end
         end
         S_INS_LAST: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = WS_NEW_AT_0;
            cmd.res_en  = 1'b1;
            cmd.res_ok  = 1'b1;
            cmd.res_ix  = IX_ZERO;
            cmd.cnt_inc = 1'b1;
            state_in    = S_RESP;
         end
         S_REM_SHIFT: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WS_SHIFT_DN;
            if (sts.addr_last) begin
               cmd.res_en  = 1'b1;
               cmd.res_ok  = 1'b1;
               cmd.cnt_dec = 1'b1;
               state_in    = S_RESP;
            end else begin
               cmd.rd_src = RS_INC;
            end
         end
         S_SEARCH: begin
            if (sts.key_eq) begin
               cmd.res_en = 1'b1;
               cmd.res_ok = 1'b1;
               if (sts.op == OP_CHANGE) begin
                  cmd.wr_en  = 1'b1;
                  cmd.wr_sel = WS_CHANGE;
               end else begin
                  cmd.res_ix  = IX_A;
                  cmd.res_val = 1'b1;
               end
               state_in = S_RESP;
            end else if (sts.addr_last || sts.key_gt) begin
               // Keys are sorted, so a larger key ends the search early.
               cmd.res_en = 1'b1;
               state_in   = S_RESP;
            end else begin
               cmd.rd_src = RS_INC;
            end
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ design/sorted_key_value_table.sv @@
// ----------------------------------------------------------------------------
// Sorted key/value table
// Keeps key/value pairs in ascending, stable key order with insert, change,
// remove and find on a walked table memory with one read and one write port.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload
//   req_if    in         operation, key, value, position
//   rsp_if    out        ok, found_index, found_value, entry_count
//
// Each accepted transaction produces exactly one response transaction. The
// work walks the table memory one entry per cycle, and the result waits in
// the response registers until it is taken. An insert walks from the end
// down to its slot and across equal keys; a remove walks from the position
// to the end; change and find walk up until the key is found or passed.
// Reset clears the entry count and the controller state only; table contents
// are undefined until written and never read before that. The request side
// is ready only while the block is idle, and a response held by rsp_if.ready
// stalls the block.
//
module sorted_key_value_table #(
   parameter int CAPACITY = skvt_pkg::CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   skvt_req_if.sink    req_if,
   skvt_rsp_if.source  rsp_if
);
   import skvt_pkg::*;

   // Command and status between the sequencing controller and the datapath.
   skvt_cmd_type cmd;
   skvt_sts_type sts;

   // The controller owns the handshake: it accepts a transaction in idle,
   // steps the datapath through the walk, and presents the result.
   skvt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the table memory, the entry count and the result
   // registers that drive the response payload while it waits.
   skvt_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_operation   (req_if.operation),
      .req_key         (req_if.key),
      .req_value       (req_if.value),
      .req_position    (req_if.position),
      .rsp_ok          (rsp_if.ok),
      .rsp_found_index (rsp_if.found_index),
      .rsp_found_value (rsp_if.found_value),
      .rsp_entry_count (rsp_if.entry_count)
   );

endmodule
